// ===== sv/klc_pkg.sv =====
// ----------------------------------------------------------------------------
// klc_pkg
// Shared types, constants and helper functions of the keyword match block.
// ----------------------------------------------------------------------------
package klc_pkg;

    localparam int MAX_PATTERN  = 32;
    localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W        = 6;
    localparam int PAT_BYTES    = 32;
    localparam int PAT_IDX_W    = 5;
    localparam int PAT_BITS     = PAT_BYTES * 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT    = 3'd6;

    localparam logic ACTION_DATA  = 1'b0;
    localparam logic ACTION_END   = 1'b1;
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0]  UPPER_FIRST  = 8'h41;
    localparam logic [7:0]  UPPER_LAST   = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;
    localparam logic [31:0] SAT32        = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic [31:0] line;
        logic [31:0] column;
    } cell_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] line;
        logic [31:0] column;
        logic [31:0] match_count;
        logic        truncated;
    } result_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic upper;
        upper = (b >= UPPER_FIRST) && (b <= UPPER_LAST);
        return (en && upper) ? b + CASE_OFFSET : b;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

// ===== sv/klc_in_if.sv =====
// ----------------------------------------------------------------------------
// klc_in_if
// Input channel: one data byte or end-of-entry marker per transaction.
// ----------------------------------------------------------------------------
interface klc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== sv/klc_out_if.sv =====
// ----------------------------------------------------------------------------
// klc_out_if
// Output channel: one match report or entry summary per transaction.
// ----------------------------------------------------------------------------
interface klc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] match_count;
    logic        truncated;

    modport source (output valid, output kind, output line, output column,
                    output match_count, output truncated, input ready);
    modport sink   (input valid, input kind, input line, input column,
                    input match_count, input truncated, output ready);
endinterface

// ===== sv/klc_cell.sv =====
// ----------------------------------------------------------------------------
// klc_cell
// One window position: holds a byte with its line and column, passes them on
// to the next cell on every shift and compares the arriving byte against its
// keyword byte.
// ----------------------------------------------------------------------------
module klc_cell
    import klc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    position,
    input  logic                shift,
    input  logic                clear,
    input  cell_t               cell_in,
    output cell_t               cell_out,
    input  logic [PAT_BITS-1:0] pattern,
    input  logic [LEN_W-1:0]    pattern_length,
    input  logic                fold_case,
    output logic                ok
);

    logic                 valid_reg;
    logic [7:0]           data_reg;
    logic [31:0]          line_reg;
    logic [31:0]          column_reg;
    logic                 active;
    logic [LEN_W-1:0]     pat_index;
    logic [7:0]           pat_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg   <= cell_in.data;
            line_reg   <= cell_in.line;
            column_reg <= cell_in.column;
        end
    end

    // The window entry at this position pairs with keyword byte length-1-position.
    always_comb
    begin
        active    = LEN_W'(position) < pattern_length;
        pat_index = pattern_length - LEN_W'(position) - LEN_W'(1);
        pat_byte  = pattern[8 * pat_index[PAT_IDX_W-1:0] +: 8];
        ok        = !active || (cell_in.valid &&
                    (fold_byte(cell_in.data, fold_case) == fold_byte(pat_byte, fold_case)));
    end

    assign cell_out = '{valid: valid_reg, data: data_reg, line: line_reg, column: column_reg};

endmodule

// ===== sv/klc_out_queue.sv =====
// ----------------------------------------------------------------------------
// klc_out_queue
// Two-entry result queue between the match logic and the output channel.
// ----------------------------------------------------------------------------
module klc_out_queue
    import klc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    klc_out_if.source out_ch
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop  = out_ch.valid && out_ch.ready;
    assign full = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_ch.valid       = (count_reg != 2'd0);
    assign out_ch.kind        = entry_reg[rd_ptr_reg].kind;
    assign out_ch.line        = entry_reg[rd_ptr_reg].line;
    assign out_ch.column      = entry_reg[rd_ptr_reg].column;
    assign out_ch.match_count = entry_reg[rd_ptr_reg].match_count;
    assign out_ch.truncated   = entry_reg[rd_ptr_reg].truncated;

endmodule

// ===== sv/keyword_match_line_column_core.sv =====
// ----------------------------------------------------------------------------
// keyword_match_line_column_core
// Streaming keyword search with line and column reporting per entry.
// ----------------------------------------------------------------------------
// The block takes one byte transaction per clock cycle and finds every
// occurrence of a keyword of up to 32 bytes, overlapping ones included. The
// bytes move through a row of 32 cells that compare in parallel, so a match
// is known in the cycle its last byte arrives and its report enters a
// two-entry output queue at the next edge. Input is accepted whenever the
// queue has a free entry; a stalled output therefore holds up the input only
// once two results are waiting. An end-of-entry transaction yields a summary
// with the match count and the truncation flag and clears the entry state in
// the same cycle.
module keyword_match_line_column_core
    import klc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    klc_in_if.sink                in_ch,
    klc_out_if.source             out_ch
);

    logic [PAT_BITS-1:0] pattern_reg;
    logic [LEN_W-1:0]    length_reg;
    logic                fold_reg;
    logic [31:0]         limit_cfg_reg;

    logic [31:0]         line_reg;
    logic [31:0]         line_next;
    logic [31:0]         column_reg;
    logic [31:0]         column_next;
    logic [31:0]         found_reg;
    logic [31:0]         found_next;
    logic                limit_reg;
    logic                limit_next;

    logic                in_acc;
    logic                shift;
    logic                clear;
    logic                queue_full;
    logic                push;
    result_t             push_data;

    logic [31:0]         byte_line;
    logic [31:0]         byte_column;
    logic [31:0]         found_inc;
    logic                len_ok;
    logic                match;
    logic [LEN_W-1:0]    len_m1;

    cell_t               cell_in  [MAX_PATTERN];
    cell_t               cell_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    assign in_ch.ready = !queue_full;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign shift       = in_acc && (in_ch.action == ACTION_DATA);
    assign clear       = in_acc && (in_ch.action == ACTION_END);

    always_comb
    begin
        if (in_ch.data_byte == NEWLINE_BYTE)
        begin
            byte_line   = sat_inc(line_reg);
            byte_column = 32'd0;
        end
        else
        begin
            byte_line   = line_reg;
            byte_column = column_reg;
        end
    end

    assign cell_in[0] = '{valid: 1'b1, data: in_ch.data_byte, line: byte_line,
                          column: byte_column};

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        if (k > 0)
        begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        klc_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .position       (IDX_W'(k)),
            .shift          (shift),
            .clear          (clear),
            .cell_in        (cell_in[k]),
            .cell_out       (cell_out[k]),
            .pattern        (pattern_reg),
            .pattern_length (length_reg),
            .fold_case      (fold_reg),
            .ok             (cell_ok[k])
        );
    end

    assign len_ok    = (length_reg != '0) && (length_reg <= LEN_W'(MAX_PATTERN));
    assign len_m1    = length_reg - LEN_W'(1);
    assign match     = shift && len_ok && (&cell_ok) && !limit_reg;
    assign found_inc = sat_inc(found_reg);

    always_comb
    begin
        line_next   = line_reg;
        column_next = column_reg;
        found_next  = found_reg;
        limit_next  = limit_reg;
        push        = 1'b0;
        push_data   = '{kind: KIND_MATCH, line: cell_in[len_m1[IDX_W-1:0]].line,
                        column: cell_in[len_m1[IDX_W-1:0]].column,
                        match_count: found_inc, truncated: limit_reg};
        if (clear)
        begin
            push        = 1'b1;
            push_data   = '{kind: KIND_SUMMARY, line: 32'd0, column: 32'd0,
                            match_count: found_reg, truncated: limit_reg};
            line_next   = 32'd1;
            column_next = 32'd1;
            found_next  = 32'd0;
            limit_next  = 1'b0;
        end
        else if (shift)
        begin
            line_next   = byte_line;
            column_next = (in_ch.data_byte == NEWLINE_BYTE) ? 32'd1 : sat_inc(column_reg);
            if (match)
            begin
                found_next = found_inc;
                limit_next = (limit_cfg_reg != 32'd0) && (found_inc >= limit_cfg_reg);
                push       = 1'b1;
                push_data.truncated = limit_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            length_reg    <= '0;
            fold_reg      <= 1'b0;
            limit_cfg_reg <= 32'd0;
            line_reg      <= 32'd1;
            column_reg    <= 32'd1;
            found_reg     <= 32'd0;
            limit_reg     <= 1'b0;
        end
        else
        begin
            line_reg   <= line_next;
            column_reg <= column_next;
            found_reg  <= found_next;
            limit_reg  <= limit_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_WORD_0: pattern_reg[0*64 +: 64] <= cfg_data;
                    CFG_PATTERN_WORD_1: pattern_reg[1*64 +: 64] <= cfg_data;
                    CFG_PATTERN_WORD_2: pattern_reg[2*64 +: 64] <= cfg_data;
                    CFG_PATTERN_WORD_3: pattern_reg[3*64 +: 64] <= cfg_data;
                    CFG_PATTERN_LENGTH: length_reg    <= cfg_data[LEN_W-1:0];
                    CFG_FOLD_CASE:      fold_reg      <= cfg_data[0];
                    CFG_MATCH_LIMIT:    limit_cfg_reg <= cfg_data[31:0];
                    default:            ;
                endcase
            end
        end
    end

    klc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .out_ch    (out_ch)
    );

`ifndef SYNTH
    a_match_shows: assert property (@(posedge clk) disable iff (!rst_n)
        match |=> out_ch.valid)
        else $error("match report not queued");

    a_entry_clears: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (found_reg == 32'd0) && !limit_reg && (line_reg == 32'd1))
        else $error("entry state not cleared after summary");

    a_limit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg && !clear |=> limit_reg)
        else $error("truncation flag dropped inside an entry");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !clear && !match |=> $stable(found_reg))
        else $error("match count changed without a match");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the keyword match block with line and column.
// ----------------------------------------------------------------------------
// A behavioral predictor tracks the byte window, line and column counters and
// match count of each entry, and queues the expected report for each match
// and summary for each end of entry. A checker pops the oldest expectation on
// each accepted output transaction and compares every field. Directed tests
// cover the special cases. Random phases then load a keyword setting each,
// and stream entries built from keyword copies, prefixes and noise. The sender
// works in bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb;
    import klc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int RANDOM_PHASES  = 12;
    localparam int PRINT_LIMIT    = 50;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW} sink_mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    klc_in_if  byte_ch ();
    klc_out_if report_ch ();

    keyword_match_line_column_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (byte_ch),
        .out_ch    (report_ch)
    );

    // Predictor state.
    logic [7:0]  win_byte [MAX_PATTERN];
    logic [31:0] win_line [MAX_PATTERN];
    logic [31:0] win_col  [MAX_PATTERN];
    int unsigned win_fill;
    logic [31:0] next_line;
    logic [31:0] next_col;
    logic [31:0] entry_matches;
    logic        entry_truncated;
    logic [63:0] kw_word [4];
    logic [LEN_W-1:0] kw_len;
    logic        kw_fold;
    logic [31:0] kw_limit;
    result_t     pending_reports [$];

    // Stimulus state.
    logic [7:0]  kw_text [PAT_BYTES];
    int          kw_span;
    int          burst_left;
    int          hold_request;
    int          hold_left;

    // Statistics.
    int          error_count;
    int          items_sent;
    int          matches_seen;
    int          summaries_seen;
    int          truncated_seen;
    int          held_cycles;
    int          input_stalls;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles.", CYCLE_LIMIT);
        $display("[keyword_match_line_column_core] ERROR");
        $finish;
    end

    function automatic logic [7:0] lower_case(input logic [7:0] b, input logic en);
        if (en && b >= UPPER_FIRST && b <= UPPER_LAST)
            return b | CASE_OFFSET;
        return b;
    endfunction

    function automatic logic [31:0] count_up(input logic [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    function automatic void add_expected(input result_t r);
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    function automatic void clear_entry_state();
        int k;
        for (k = 0; k < MAX_PATTERN; k++)
        begin
            win_byte[k] = '0;
            win_line[k] = '0;
            win_col[k]  = '0;
        end
        win_fill        = 0;
        next_line       = 32'd1;
        next_col        = 32'd1;
        entry_matches   = '0;
        entry_truncated = 1'b0;
    endfunction

    function automatic void track_item(input logic action, input logic [7:0] data);
        result_t     r;
        logic [31:0] ln;
        logic [31:0] col;
        int unsigned len;
        int          k;
        if (action == ACTION_END)
        begin
            r.kind        = KIND_SUMMARY;
            r.line        = '0;
            r.column      = '0;
            r.match_count = entry_matches;
            r.truncated   = entry_truncated;
            add_expected(r);
            clear_entry_state();
            return;
        end
        if (data == NEWLINE_BYTE)
        begin
            next_line = count_up(next_line);
            ln        = next_line;
            col       = '0;
            next_col  = 32'd1;
        end
        else
        begin
            ln       = next_line;
            col      = next_col;
            next_col = count_up(next_col);
        end
        for (k = MAX_PATTERN - 1; k > 0; k--)
        begin
            win_byte[k] = win_byte[k-1];
            win_line[k] = win_line[k-1];
            win_col[k]  = win_col[k-1];
        end
        win_byte[0] = data;
        win_line[0] = ln;
        win_col[0]  = col;
        if (win_fill < MAX_PATTERN)
            win_fill++;
        len = kw_len;
        if (len == 0 || len > MAX_PATTERN || win_fill < len || entry_truncated)
            return;
        for (k = 0; k < len; k++)
        begin
            if (lower_case(win_byte[len-1-k], kw_fold) !=
                lower_case(kw_word[k/8][(k%8)*8 +: 8], kw_fold))
                return;
        end
        entry_matches = count_up(entry_matches);
        if (kw_limit != 0 && entry_matches >= kw_limit)
            entry_truncated = 1'b1;
        r.kind        = KIND_MATCH;
        r.line        = win_line[len-1];
        r.column      = win_col[len-1];
        r.match_count = entry_matches;
        r.truncated   = entry_truncated;
        add_expected(r);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("Mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_report();
        result_t want;
        if (pending_reports.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transaction, kind %0d count %0d",
                                      report_ch.kind, report_ch.match_count));
            return;
        end
        want = pending_reports.pop_front();
        if (report_ch.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", report_ch.kind, want.kind));
        if (report_ch.line !== want.line)
            report_mismatch($sformatf("line %0d, expected %0d", report_ch.line, want.line));
        if (report_ch.column !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d",
                                      report_ch.column, want.column));
        if (report_ch.match_count !== want.match_count)
            report_mismatch($sformatf("match_count %0d, expected %0d",
                                      report_ch.match_count, want.match_count));
        if (report_ch.truncated !== want.truncated)
            report_mismatch($sformatf("truncated %0d, expected %0d",
                                      report_ch.truncated, want.truncated));
        if (want.kind == KIND_SUMMARY)
            summaries_seen++;
        else
            matches_seen++;
        if (want.truncated)
            truncated_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && report_ch.valid && report_ch.ready)
            check_report();
        if (rst_n && byte_ch.valid && !byte_ch.ready)
            input_stalls++;
    end

    // The receiver changes its stall pattern at random and honors a requested
    // hold-off by keeping ready low until the hold-off has run out.
    initial
    begin
        sink_mode_e mode;
        int         mode_left;
        report_ch.ready = 1'b0;
        mode            = SINK_OPEN;
        mode_left       = 0;
        hold_left       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                held_cycles++;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_e'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN: report_ch.ready <= 1'b1;
                    SINK_COIN: report_ch.ready <= 1'($urandom_range(0, 1));
                    default:   report_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input logic action, input logic [7:0] data);
        pace();
        byte_ch.valid     <= 1'b1;
        byte_ch.action    <= action;
        byte_ch.data_byte <= data;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        track_item(action, data);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(ACTION_DATA, s[i]);
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_PATTERN_WORD_0: kw_word[0] = value;
            CFG_PATTERN_WORD_1: kw_word[1] = value;
            CFG_PATTERN_WORD_2: kw_word[2] = value;
            CFG_PATTERN_WORD_3: kw_word[3] = value;
            CFG_PATTERN_LENGTH: kw_len     = value[LEN_W-1:0];
            CFG_FOLD_CASE:      kw_fold    = value[0];
            CFG_MATCH_LIMIT:    kw_limit   = value[31:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pack_word(input int w);
        logic [63:0] word;
        int          b;
        for (b = 0; b < 8; b++)
            word[b*8 +: 8] = kw_text[w*8 + b];
        return word;
    endfunction

    function automatic void set_text(input string s);
        int i;
        for (i = 0; i < PAT_BYTES; i++)
            kw_text[i] = (i < s.len()) ? s[i] : 8'h00;
    endfunction

    task automatic load_keyword(input int len_value, input logic fold, input logic [31:0] limit);
        wait_idle();
        write_reg(CFG_PATTERN_WORD_0, pack_word(0));
        write_reg(CFG_PATTERN_WORD_1, pack_word(1));
        write_reg(CFG_PATTERN_WORD_2, pack_word(2));
        write_reg(CFG_PATTERN_WORD_3, pack_word(3));
        write_reg(CFG_PATTERN_LENGTH, 64'(len_value));
        write_reg(CFG_FOLD_CASE, 64'(fold));
        write_reg(CFG_MATCH_LIMIT, 64'(limit));
        kw_span = (len_value > PAT_BYTES) ? PAT_BYTES : len_value;
    endtask

    function automatic logic [7:0] vary_case(input logic [7:0] b);
        logic letter;
        letter = (b >= UPPER_FIRST && b <= UPPER_LAST) ||
                 (b >= (UPPER_FIRST | CASE_OFFSET) && b <= (UPPER_LAST | CASE_OFFSET));
        if (letter && $urandom_range(0, 3) == 0)
            return b ^ CASE_OFFSET;
        return b;
    endfunction

    function automatic logic [7:0] keyword_letter();
        case ($urandom_range(0, 9))
            0, 1:    return "a";
            2, 3:    return "b";
            4:       return "A";
            5:       return "B";
            6:       return NEWLINE_BYTE;
            7:       return "c";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return NEWLINE_BYTE;
            1:       return 8'($urandom_range(0, 255));
            default: return vary_case(kw_text[$urandom_range(0, kw_span - 1)]);
        endcase
    endfunction

    task automatic send_keyword_prefix(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_item(ACTION_DATA, vary_case(kw_text[i]));
    endtask

    task automatic send_entry();
        int pieces;
        int p;
        int i;
        int pick;
        pieces = $urandom_range(0, (kw_span > 8) ? 4 : 8);
        for (p = 0; p < pieces; p++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_keyword_prefix(kw_span);
            else if (pick < 7)
                send_keyword_prefix($urandom_range(1, kw_span));
            else
                for (i = $urandom_range(1, 4); i > 0; i--)
                    send_item(ACTION_DATA, noise_byte());
        end
        send_item(ACTION_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic pick_phase(input int phase);
        int          i;
        int          len_value;
        logic        fold;
        logic [31:0] limit;
        fold  = 1'($urandom_range(0, 1));
        limit = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 5);
        len_value = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        case (phase)
            0:       len_value = MAX_PATTERN;
            1:       len_value = 3;
            2:       begin len_value = MAX_PATTERN; fold = 1'b1; limit = SAT32; end
            3:       len_value = $urandom_range(MAX_PATTERN + 1, 63);
            default: ;
        endcase
        for (i = 0; i < PAT_BYTES; i++)
        begin
            if (phase == 0)
                kw_text[i] = 8'hFF;
            else if (phase == 1)
                kw_text[i] = 8'h00;
            else
                kw_text[i] = (i < len_value) ? keyword_letter() : 8'($urandom_range(0, 255));
        end
        load_keyword(len_value, fold, limit);
    endtask

    task automatic test_empty_keyword();
        send_item(ACTION_DATA, 8'h00);
        send_item(ACTION_DATA, 8'hFF);
        send_item(ACTION_END, 8'hA5);
    endtask

    task automatic test_newline_start();
        set_text("\nab");
        load_keyword(3, 1'b0, 32'd0);
        send_text("x\nab");
        send_item(ACTION_END, 8'h00);
    endtask

    task automatic test_fold_overlap();
        set_text("Aa");
        load_keyword(2, 1'b1, 32'd0);
        send_text("aAa");
        send_item(ACTION_END, 8'hFF);
    endtask

    task automatic test_limit_latch();
        set_text("a");
        load_keyword(1, 1'b0, 32'd1);
        send_text("aa");
        wait_idle();
        write_reg(CFG_MATCH_LIMIT, 64'd0);
        send_text("a");
        send_item(ACTION_END, 8'h00);
    endtask

    task automatic test_mid_entry_write();
        set_text("abc");
        load_keyword(3, 1'b0, 32'd0);
        send_text("AB");
        wait_idle();
        write_reg(CFG_FOLD_CASE, 64'd1);
        send_text("c");
        send_item(ACTION_END, 8'h00);
    endtask

    task automatic test_ignored_writes();
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, '1);
        write_reg(CFG_PATTERN_LENGTH, '1);
        send_text("a");
        send_item(ACTION_END, 8'h00);
    endtask

    task automatic test_backpressure();
        int i;
        set_text("a");
        load_keyword(1, 1'b0, 32'd0);
        @(posedge clk);
        hold_request = 150;
        @(negedge clk);
        for (i = 0; i < 30; i++)
            send_item(ACTION_DATA, "a");
        send_item(ACTION_END, 8'h00);
    endtask

    task automatic test_random_entries();
        int phase;
        int start_count;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_phase(phase);
            start_count = items_sent;
            while (items_sent - start_count < RANDOM_ITEMS / RANDOM_PHASES)
                send_entry();
        end
    endtask

    initial
    begin
        int k;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.action    = ACTION_DATA;
        byte_ch.data_byte = '0;
        hold_request      = 0;
        burst_left        = 0;
        error_count       = 0;
        items_sent        = 0;
        matches_seen      = 0;
        summaries_seen    = 0;
        truncated_seen    = 0;
        held_cycles       = 0;
        input_stalls      = 0;
        clear_entry_state();
        for (k = 0; k < 4; k++)
            kw_word[k] = '0;
        kw_len   = '0;
        kw_fold  = 1'b0;
        kw_limit = '0;
        set_text("");
        kw_span = 1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_keyword();
        test_newline_start();
        test_fold_overlap();
        test_limit_latch();
        test_mid_entry_write();
        test_ignored_writes();
        test_backpressure();
        test_random_entries();

        byte_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d input transactions; checked %0d matches, %0d summaries, %0d truncated.",
                 items_sent, matches_seen, summaries_seen, truncated_seen);
        $display("Output held off for %0d cycles; input stalled on %0d cycles; %0d mismatches.",
                 held_cycles, input_stalls, error_count);
        if (error_count == 0 && pending_reports.size() == 0)
            $display("[keyword_match_line_column_core] OK");
        else
            $display("[keyword_match_line_column_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/klc_pkg.sv
sv/klc_in_if.sv
sv/klc_out_if.sv
sv/klc_cell.sv
sv/klc_out_queue.sv
sv/keyword_match_line_column_core.sv
tb/sv/tb.sv
